// ----- rtl/sib_pkg.sv -----
// Package for the sorted insert buffer: payload types, command and status codes.
package sib_pkg;

  // Input command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_ELEMENT  = 2'd3
  } status_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] new_value;
    logic signed [31:0] head_value;
  } cell_ctrl_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

endpackage

// ----- rtl/sorted_insert_buffer.sv -----
// Sorted insert buffer: ascending list of signed values kept in a chain of cells.
// Insert: one transaction per cycle while output is free; result registered on accept.
// Readout of n values: n results, one per cycle while output is free, each set by one
// chain rotation step; next transaction is taken after the final result is registered.
// Empty readout or full insert gives one result, registered on accept.
// Reset (synchronous) empties the list and clears the output valid flag.
module sorted_insert_buffer
  import sib_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] cell_data  [DEPTH];
  logic               cell_valid [DEPTH];
  logic               cell_take  [DEPTH];
  cell_ctrl_t         ctrl;

  logic          busy;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_left;
  logic          out_free;
  logic          accept;
  logic          full;
  logic          emit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = cell_valid[DEPTH-1];
  assign emit     = busy && out_free;

  // Chain control
  always_comb begin
    ctrl.new_value  = in_item.value;
    ctrl.head_value = cell_data[0];
    if (accept && in_item.cmd == CMD_INSERT && !full) begin
      ctrl.op = CELL_INSERT;
    end else if (emit) begin
      ctrl.op = CELL_ROTATE;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               p_take;
    logic signed [31:0] p_data;
    logic               p_valid;
    logic signed [31:0] n_data;
    logic               n_valid;

    if (i == 0) begin : g_first
      assign p_take  = 1'b0;
      assign p_data  = '0;
      assign p_valid = 1'b0;
    end else begin : g_mid
      assign p_take  = cell_take[i-1];
      assign p_data  = cell_data[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_data  = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_data  = cell_data[i+1];
      assign n_valid = cell_valid[i+1];
    end

    sib_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_take  (p_take),
      .prev_data  (p_data),
      .prev_valid (p_valid),
      .next_data  (n_data),
      .next_valid (n_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .take       (cell_take[i])
    );
  end

  // Sequencing: count, readout progress, output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      rd_left   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
        if (in_item.cmd == CMD_INSERT) begin
          if (!full) begin
            count <= count + CW'(1);
          end
        end else if (count != '0) begin
          out_valid <= 1'b0;
          busy      <= 1'b1;
          rd_left   <= count;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
        rd_left   <= rd_left - CW'(1);
        if (rd_left == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.out_value <= '0;
      out_item.last      <= 1'b1;
      if (in_item.cmd == CMD_INSERT) begin
        out_item.status <= full ? ST_FULL : ST_INSERTED;
      end else begin
        out_item.status <= ST_EMPTY;
      end
    end else if (emit) begin
      out_item.status    <= ST_ELEMENT;
      out_item.out_value <= cell_data[0];
      out_item.last      <= (rd_left == CW'(1));
    end
  end

endmodule

// ----- rtl/sib_cell.sv -----
// One storage cell of the sorted chain: compares, shifts on insert, rotates on readout.
module sib_cell
  import sib_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic               prev_take,
  input  logic signed [31:0] prev_data,
  input  logic               prev_valid,
  input  logic signed [31:0] next_data,
  input  logic               next_valid,
  output logic signed [31:0] data,
  output logic               valid,
  output logic               take
);

  logic               gt;
  logic signed [31:0] data_next;
  logic               valid_next;

  // Insert point is the first cell holding a larger value, or the first empty one
  assign gt   = valid && (data > ctrl.new_value);
  assign take = gt || !valid;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (prev_take) begin
          data_next  = prev_data;
          valid_next = prev_valid;
        end else if (take) begin
          data_next  = ctrl.new_value;
          valid_next = 1'b1;
        end
      end
      CELL_ROTATE: begin
        // Tail of the list takes the old head; others take their right neighbor
        if (valid) begin
          data_next = next_valid ? next_data : ctrl.head_value;
        end
      end
      default: begin
        data_next  = data;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
